// ===== hdl/kdpc_pkg.sv =====
`default_nettype none

package kdpc_pkg;

	localparam int ADDR_W = 4;
	localparam int DATA_W = 32;

	// register byte offsets
	localparam logic [ADDR_W-1:0] REG_ACTIVE_HIGH = 4'h0;
	localparam logic [ADDR_W-1:0] REG_DEBOUNCE    = 4'h4;
	localparam logic [ADDR_W-1:0] REG_LONG_PRESS  = 4'h8;

	localparam logic [1:0] ACT_SAMPLE = 2'd0;
	localparam logic [1:0] ACT_READ   = 2'd1;
	localparam logic [1:0] ACT_START  = 2'd2;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_SHORT = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;

	localparam int DEB_W  = 16;
	localparam int LONG_W = 24;

	typedef struct packed {
		logic [1:0]  action;
		logic        pin_level;
		logic [31:0] now_tick;
	} in_t;

	typedef struct packed {
		logic [1:0] event_code;
		logic       pressed;
	} out_t;

	typedef struct packed {
		logic              active_high;
		logic [DEB_W-1:0]  debounce_ticks;
		logic [LONG_W-1:0] long_press_ticks;
	} cfg_t;

	typedef struct packed {
		logic       raw_last;
		logic       stable_level;
		logic       long_fired;
		logic [1:0] pending_event;
	} flags_t;

endpackage

`default_nettype wire

// ===== hdl/kdpc_step.sv =====
`default_nettype none

// Next-state and result logic for one word.
module kdpc_step #(
	parameter int TICK_BITS = 32
) (
	input  kdpc_pkg::in_t          item,
	input  kdpc_pkg::cfg_t         cfg,
	input  kdpc_pkg::flags_t       flags,
	input  logic [TICK_BITS-1:0]   change_tick,
	input  logic [TICK_BITS-1:0]   press_start,
	output kdpc_pkg::flags_t       flags_nxt,
	output logic [TICK_BITS-1:0]   change_tick_nxt,
	output logic [TICK_BITS-1:0]   press_start_nxt,
	output kdpc_pkg::out_t         result
);

	localparam int CW = (TICK_BITS > kdpc_pkg::LONG_W) ? TICK_BITS : kdpc_pkg::LONG_W;

	logic [TICK_BITS-1:0] now;
	logic [TICK_BITS-1:0] ct_smp;
	logic [TICK_BITS-1:0] deb_el;
	logic [TICK_BITS-1:0] ps_smp;
	logic [TICK_BITS-1:0] long_el;
	logic                 deb_done;
	logic                 long_done;
	logic                 take;
	kdpc_pkg::flags_t     f;

	assign now = TICK_BITS'(item.now_tick);

	always_comb begin
		f               = flags;
		change_tick_nxt = change_tick;
		press_start_nxt = press_start;
		result          = '0;
		ct_smp          = (item.pin_level != flags.raw_last) ? now : change_tick;
		deb_el          = now - ct_smp;
		deb_done        = CW'(deb_el) >= CW'(cfg.debounce_ticks);
		take            = deb_done && (flags.stable_level != item.pin_level);
		ps_smp          = (take && (item.pin_level == cfg.active_high)) ? now : press_start;
		long_el         = now - ps_smp;
		long_done       = CW'(long_el) >= CW'(cfg.long_press_ticks);
		case (item.action)
			kdpc_pkg::ACT_SAMPLE: begin
				f.raw_last      = item.pin_level;
				change_tick_nxt = ct_smp;
				press_start_nxt = ps_smp;
				if (take) begin
					f.stable_level = item.pin_level;
					if (item.pin_level == cfg.active_high)
						f.long_fired = 1'b0;
					else if (!flags.long_fired)
						f.pending_event = kdpc_pkg::EV_SHORT;
				end
				// long press fires once, judged on the updated level
				if ((f.stable_level == cfg.active_high) && !f.long_fired && long_done) begin
					f.long_fired    = 1'b1;
					f.pending_event = kdpc_pkg::EV_LONG;
				end
			end
			kdpc_pkg::ACT_READ: begin
				result.event_code = flags.pending_event;
				f.pending_event   = kdpc_pkg::EV_NONE;
			end
			kdpc_pkg::ACT_START: begin
				f.raw_last      = item.pin_level;
				f.stable_level  = item.pin_level;
				change_tick_nxt = now;
			end
			default: ;
		endcase
		result.pressed = (f.stable_level == cfg.active_high);
		flags_nxt      = f;
	end

endmodule

`default_nettype wire

// ===== hdl/key_debounce_press_classifier.sv =====
// An accepted input word passes the input register, then the result register, to the output.
// Throughput: one word per cycle while out_stall allows; the key state updates in the same cycle
// as the result register, so the next word sees it without a bubble.
// Reset (arst_n low): key state, pending event and config registers go to zero,
// both pipeline slots empty.
`default_nettype none

module key_debounce_press_classifier #(
	parameter int TICK_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  kdpc_pkg::in_t                 in_word,
	output logic                          out_valid,
	input  logic                          out_stall,
	output kdpc_pkg::out_t                out_word,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [kdpc_pkg::ADDR_W-1:0]   paddr,
	input  logic [kdpc_pkg::DATA_W-1:0]   pwdata,
	output logic [kdpc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);

	kdpc_pkg::cfg_t       cfg_q;
	kdpc_pkg::flags_t     flags_q;
	kdpc_pkg::flags_t     flags_nxt;
	logic [TICK_BITS-1:0] change_tick_q;
	logic [TICK_BITS-1:0] change_tick_nxt;
	logic [TICK_BITS-1:0] press_start_q;
	logic [TICK_BITS-1:0] press_start_nxt;
	kdpc_pkg::in_t        item_s1;
	logic                 valid_s1;
	kdpc_pkg::out_t       result;
	kdpc_pkg::out_t       out_q;
	logic                 out_valid_q;
	logic                 out_ready;
	logic                 advance;
	logic                 cfg_wr;

	assign pready    = 1'b1;
	assign cfg_wr    = psel && penable && pwrite;
	assign out_ready = !out_valid_q || !out_stall;
	assign advance   = valid_s1 && out_ready;
	assign in_stall  = valid_s1 && !out_ready;
	assign out_valid = out_valid_q;
	assign out_word  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr) begin
			unique case (paddr)
				kdpc_pkg::REG_ACTIVE_HIGH: cfg_q.active_high      <= pwdata[0];
				kdpc_pkg::REG_DEBOUNCE:    cfg_q.debounce_ticks   <= pwdata[kdpc_pkg::DEB_W-1:0];
				kdpc_pkg::REG_LONG_PRESS:  cfg_q.long_press_ticks <= pwdata[kdpc_pkg::LONG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr)
			kdpc_pkg::REG_ACTIVE_HIGH: prdata = kdpc_pkg::DATA_W'(cfg_q.active_high);
			kdpc_pkg::REG_DEBOUNCE:    prdata = kdpc_pkg::DATA_W'(cfg_q.debounce_ticks);
			kdpc_pkg::REG_LONG_PRESS:  prdata = kdpc_pkg::DATA_W'(cfg_q.long_press_ticks);
			default:                   prdata = '0;
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (!in_stall)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall)
			item_s1 <= in_word;
	end

	kdpc_step #(
		.TICK_BITS(TICK_BITS)
	) u_step (
		.item            (item_s1),
		.cfg             (cfg_q),
		.flags           (flags_q),
		.change_tick     (change_tick_q),
		.press_start     (press_start_q),
		.flags_nxt       (flags_nxt),
		.change_tick_nxt (change_tick_nxt),
		.press_start_nxt (press_start_nxt),
		.result          (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_q       <= '0;
			change_tick_q <= '0;
			press_start_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (advance) begin
				flags_q       <= flags_nxt;
				change_tick_q <= change_tick_nxt;
				press_start_q <= press_start_nxt;
			end
			if (out_ready)
				out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			out_q <= result;
	end

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

	a_read_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.action == kdpc_pkg::ACT_READ) |=>
		flags_q.pending_event == kdpc_pkg::EV_NONE)
		else $error("read did not clear pending event");

	a_pressed_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.pressed == (flags_q.stable_level == cfg_q.active_high))
		else $error("pressed flag disagrees with stable level");

	a_event_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.action != kdpc_pkg::ACT_READ) |=>
		out_q.event_code == kdpc_pkg::EV_NONE)
		else $error("event reported on a non-read word");

	a_tick_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && item_s1.action == kdpc_pkg::ACT_READ) |=>
		$stable(change_tick_q) && $stable(press_start_q))
		else $error("read word changed timer state");

endmodule

`default_nettype wire
